>>> rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions for the LRU key-value cache
// Default sizes, the capacity register format and the request action codes.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_SET = 1'b1
  } action_t;

endpackage

>>> rtl/core/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Gets and sets are resolved by scanning the key RAM one entry per cycle;
// recency ranks live in a row of registers, all updated in the same cycle.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------
//  request   start / busy         action, key, value
//  result    done (strobe)        hit, read_value
//  config    cfg_valid/cfg_ready  cfg_data (capacity)
//
// A request is resolved by scanning the key RAM from the first entry; the scan
// stops at the matching entry on a hit and after the last entry on a miss,
// and a get hit then also reads the value RAM. The scan is bound by the single read
// port of the key RAM, which it walks one entry per cycle.
// Reset is synchronous and empties the cache; capacity returns to 16.
// The result strobe lasts one cycle and cannot be stalled; busy falls in
// that same cycle, so the next request may be accepted alongside it.
module lru_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [VALUE_BITS-1:0]      value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data,
  output logic                       done,
  output logic                       hit,
  output logic [VALUE_BITS-1:0]      read_value
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_VREAD
  } state_t;

  state_t state;

  logic [lkvc_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]           entry_count;
  logic [ENTRIES-1:0]         valid;
  logic [IDX_W-1:0]           rank [ENTRIES];

  logic                  req_action;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  logic [IDX_W-1:0] issue_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_live;
  logic             found;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] slot_rank;
  logic             free_seen;
  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] oldest_slot;

  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;

  logic             ent_valid;
  logic [IDX_W-1:0] ent_rank;
  logic             ent_hit;
  logic             ent_oldest;
  logic [CNT_W-1:0] cap_eff;
  logic             full;
  logic [IDX_W-1:0] wr_slot;
  logic             key_we;
  logic             val_we;
  logic             touch_en;
  logic             ins_en;
  logic [IDX_W-1:0] touch_rank;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Effective capacity: zero counts as one, anything above the store size
  // saturates to it.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign full = (entry_count >= cap_eff);

  // The entry under comparison is one behind the RAM address just issued.
  assign ent_valid  = valid[cmp_idx];
  assign ent_rank   = rank[cmp_idx];
  assign ent_hit    = cmp_live && ent_valid && (key_rdata == req_key);
  assign ent_oldest = cmp_live && ent_valid &&
                      (CNT_W'(ent_rank) == (entry_count - CNT_W'(1)));

  assign wr_slot = found ? slot : (full ? oldest_slot : free_slot);
  assign key_we  = (state == ST_DECIDE) && (req_action == lkvc_pkg::ACT_SET) && !found;
  assign val_we  = (state == ST_DECIDE) && (req_action == lkvc_pkg::ACT_SET);

  assign touch_en = (state == ST_VREAD) ||
                    ((state == ST_DECIDE) && (req_action == lkvc_pkg::ACT_SET) &&
                     (found || full));
  assign ins_en   = (state == ST_DECIDE) && (req_action == lkvc_pkg::ACT_SET) &&
                    !found && !full;
  // An evicted entry always holds the oldest rank, one below the count.
  assign touch_rank = found ? slot_rank : IDX_W'(entry_count - CNT_W'(1));

  lkvc_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_slot),
    .wdata (req_key),
    .raddr (issue_idx),
    .rdata (key_rdata)
  );

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_slot),
    .wdata (req_value),
    .raddr (slot),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      capacity    <= lkvc_pkg::CAP_RESET;
      entry_count <= '0;
      valid       <= '0;
      done        <= 1'b0;
      cmp_live    <= 1'b0;
      found       <= 1'b0;
      free_seen   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req_action <= action;
            req_key    <= key;
            req_value  <= value;
            issue_idx  <= '0;
            cmp_live   <= 1'b0;
            found      <= 1'b0;
            free_seen  <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          issue_idx <= issue_idx + 1'b1;
          cmp_idx   <= issue_idx;
          cmp_live  <= 1'b1;
          if (cmp_live && !ent_valid && !free_seen) begin
            free_seen <= 1'b1;
            free_slot <= cmp_idx;
          end
          if (ent_oldest) begin
            oldest_slot <= cmp_idx;
          end
          if (ent_hit) begin
            found     <= 1'b1;
            slot      <= cmp_idx;
            slot_rank <= ent_rank;
            state     <= ST_DECIDE;
          end else if (cmp_live && (cmp_idx == LAST)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if ((req_action == lkvc_pkg::ACT_GET) && found) begin
            state <= ST_VREAD;
          end else begin
            done       <= 1'b1;
            hit        <= found;
            read_value <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_VREAD: begin
          done       <= 1'b1;
          hit        <= 1'b1;
          read_value <= val_rdata;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Recency update: a touch ages the entries younger than the touched one,
      // an insert ages every valid entry.
      for (int i = 0; i < ENTRIES; i++) begin
        if (touch_en) begin
          if (valid[i] && (IDX_W'(i) != wr_slot) && (rank[i] < touch_rank)) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end else if (ins_en && valid[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      if (touch_en || ins_en) begin
        rank[wr_slot] <= '0;
      end
      if (ins_en) begin
        valid[wr_slot] <= 1'b1;
        entry_count    <= entry_count + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (read_value == '0))
    else $error("miss returned a non-zero value");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(entry_count))
    else $error("entry count differs from the number of valid entries");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= ENTRIES)
    else $error("entry count exceeds the store size");
`endif

endmodule
